FILE: src/palette_video_serializer_macros.svh
// assertion helpers shared by the checker
`ifndef PALETTE_VIDEO_SERIALIZER_MACROS_SVH
`define PALETTE_VIDEO_SERIALIZER_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define PVS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define PVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/pvs_pkg.sv
package pvs_pkg;

   // widths fixed by the item fields
   localparam int PEN_W        = 5;
   localparam int COLOUR_W     = 5;
   localparam int RGB_W        = 24;
   localparam int PIX_IDX_W    = 3;
   localparam int PEN_COUNT_DEF = 17;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [PEN_W-1:0]     BORDER_PEN = 5'd16;
   localparam logic [PIX_IDX_W-1:0] LAST_PIXEL = 3'd7;

   // item kinds
   localparam logic [1:0] KIND_BUS_WRITE = 2'd0;
   localparam logic [1:0] KIND_VIDEO     = 2'd1;
   localparam logic [1:0] KIND_BORDER    = 2'd2;

   // bus write functions, data bits 7:6
   localparam logic [1:0] BUS_SELECT_PEN = 2'd0;
   localparam logic [1:0] BUS_SET_COLOUR = 2'd1;
   localparam logic [1:0] BUS_SET_MODE   = 2'd2;

   // video modes
   localparam logic [1:0] MODE_16_COLOUR = 2'd0;
   localparam logic [1:0] MODE_4_COLOUR  = 2'd1;
   localparam logic [1:0] MODE_2_COLOUR  = 2'd2;
   localparam logic [1:0] MODE_BORDER    = 2'd3;
   localparam logic [1:0] MODE_RESET     = MODE_4_COLOUR;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [RGB_W-1:0] pixel_rgb;
      logic             last;
   } rsp_payload_type;

   typedef enum logic {
      OP_PEN_WRITE,
      OP_PIXELS
   } cmd_op_type;

   // queued command: pen write or a run of eight pixels
   typedef struct packed {
      cmd_op_type       op;
      logic [1:0]       mode;
      logic [PEN_W-1:0] pen;
      logic [7:0]       data;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   // hardware colour to rgb, indices past the rom give black
   function automatic logic [RGB_W-1:0] colour_rom(input logic [COLOUR_W-1:0] hw);
      logic [RGB_W-1:0] rgb;
      case (hw)
         5'd0:    rgb = 24'h808080;
         5'd1:    rgb = 24'h808080;
         5'd2:    rgb = 24'h00FF80;
         5'd3:    rgb = 24'hFFFF80;
         5'd4:    rgb = 24'h000080;
         5'd5:    rgb = 24'hFF0080;
         5'd6:    rgb = 24'h008080;
         5'd7:    rgb = 24'hFF8080;
         5'd8:    rgb = 24'hFF0080;
         5'd9:    rgb = 24'hFFFF80;
         5'd10:   rgb = 24'hFFFF00;
         5'd11:   rgb = 24'hFFFFFF;
         5'd12:   rgb = 24'hFF0000;
         5'd13:   rgb = 24'hFF00FF;
         5'd14:   rgb = 24'hFF8000;
         5'd15:   rgb = 24'hFF80FF;
         5'd16:   rgb = 24'h000080;
         5'd17:   rgb = 24'h00FF80;
         5'd18:   rgb = 24'h00FF00;
         5'd19:   rgb = 24'h00FFFF;
         5'd20:   rgb = 24'h000000;
         5'd21:   rgb = 24'h0000FF;
         5'd22:   rgb = 24'h008000;
         5'd23:   rgb = 24'h0080FF;
         5'd24:   rgb = 24'h800080;
         5'd25:   rgb = 24'h8000FF;
         5'd26:   rgb = 24'h800000;
         default: rgb = 24'h000000;
      endcase
      return rgb;
   endfunction

   // power-on palette
   function automatic logic [COLOUR_W-1:0] power_on_colour(input logic [PEN_W-1:0] pen);
      logic [COLOUR_W-1:0] c;
      case (pen)
         5'd1:    c = 5'd24;
         5'd3:    c = 5'd12;
         5'd5:    c = 5'd26;
         5'd7:    c = 5'd18;
         5'd9:    c = 5'd6;
         5'd11:   c = 5'd14;
         5'd13:   c = 5'd10;
         5'd15:   c = 5'd22;
         default: c = 5'd20;
      endcase
      return c;
   endfunction

   // pen of pixel x of a video byte in the given mode
   function automatic logic [PEN_W-1:0] decode_pen(input logic [7:0] b,
                                                   input logic [1:0] mode,
                                                   input logic [PIX_IDX_W-1:0] x);
      logic [PEN_W-1:0] pen;
      logic [1:0]       p;
      p = x[2:1];
      case (mode)
         MODE_16_COLOUR: begin
            if (!x[2]) pen = {1'b0, b[1], b[3], b[5], b[7]};
            else       pen = {1'b0, b[0], b[2], b[4], b[6]};
         end
         MODE_4_COLOUR: pen = {3'b000, b[{1'b0, ~p}], b[{1'b1, ~p}]};
         MODE_2_COLOUR: pen = {4'b0000, b[~x]};
         default:       pen = BORDER_PEN;
      endcase
      return pen;
   endfunction

endpackage

FILE: src/palette_video_serializer.sv
// palette video serializer
//
// req channel: one transaction per item (kind, value). bus writes select a pen,
// set its hardware colour or set the video mode; video bytes and border slots
// each produce eight 24-bit rgb pixels on the rsp channel, last set on the eighth.
// bus writes and unused kinds produce nothing.
//
// a front stage takes transactions, tracks pen select and mode and pushes
// commands into a four-entry queue; the back stage runs one pixel per cycle,
// while the output is not stalled, through the palette and colour rom into the
// output register. a command is registered in a queue entry and its pixels in
// the output register. video bytes and border slots share the single pixel lane
// of the back stage; a colour write occupies the back stage in place of a pixel,
// pen select and mode writes never reach it.
//
// reset: pen select 0, mode 1, power-on palette, queue and output empty.
// while rsp_stall is high the current pixel holds; the queue keeps taking
// transactions until full, then req_stall rises.
module palette_video_serializer
   import pvs_pkg::*;
#(
   parameter int PEN_COUNT   = PEN_COUNT_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   // classify and track pen select and mode
   pvs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push)
   );

   // command queue between the two stages
   pvs_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // palette, pixel decode and output register
   pvs_back #(
      .PEN_COUNT (PEN_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/pvs_front.sv
module pvs_front
   import pvs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   input  logic            queue_full,
   output push_type        push
);

   logic [PEN_W-1:0] selected_pen_ff, selected_pen_in;
   logic [1:0]       video_mode_ff, video_mode_in;
   logic             accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // classify the transaction, keep pen select and mode here
   always_comb begin
      selected_pen_in = selected_pen_ff;
      video_mode_in   = video_mode_ff;
      push.push       = 1'b0;
      push.cmd.op     = OP_PIXELS;
      push.cmd.mode   = video_mode_ff;
      push.cmd.pen    = selected_pen_ff;
      push.cmd.data   = req_data.value;
      if (accept) begin
         case (req_data.kind)
            KIND_BUS_WRITE: begin
               case (req_data.value[7:6])
                  BUS_SELECT_PEN: begin
                     selected_pen_in = req_data.value[4] ? BORDER_PEN
                                                         : {1'b0, req_data.value[3:0]};
                  end
                  BUS_SET_COLOUR: begin
                     push.push   = 1'b1;
                     push.cmd.op = OP_PEN_WRITE;
                  end
                  BUS_SET_MODE: video_mode_in = req_data.value[1:0];
                  default: ;
               endcase
            end
            KIND_VIDEO: push.push = 1'b1;
            KIND_BORDER: begin
               push.push     = 1'b1;
               push.cmd.mode = MODE_BORDER;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         selected_pen_ff <= '0;
         video_mode_ff   <= MODE_RESET;
      end else begin
         selected_pen_ff <= selected_pen_in;
         video_mode_ff   <= video_mode_in;
      end
   end

endmodule

FILE: src/pvs_queue.sv
module pvs_queue
   import pvs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push.push && !full;
   assign do_pop     = pop && head.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push.cmd;
   end

endmodule

FILE: src/pvs_back.sv
module pvs_back
   import pvs_pkg::*;
#(
   parameter int PEN_COUNT = PEN_COUNT_DEF
)(
   input  logic            clock,
   input  logic            reset,
   input  head_type        head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic [COLOUR_W-1:0]  palette_ff [PEN_COUNT];
   logic [PIX_IDX_W-1:0] pixel_ff, pixel_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;
   logic                 out_free;
   logic                 pen_we;
   logic [PEN_W-1:0]     pen_sel;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pen_sel   = decode_pen(head.cmd.data, head.cmd.mode, pixel_ff);

   // execute the command at the queue head
   always_comb begin
      pop          = 1'b0;
      pen_we       = 1'b0;
      pixel_in     = pixel_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) rsp_valid_in = 1'b0;
      if (head.valid) begin
         case (head.cmd.op)
            OP_PEN_WRITE: begin
               pop    = 1'b1;
               pen_we = 1'b1;
            end
            OP_PIXELS: begin
               if (out_free) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.pixel_rgb = colour_rom(palette_ff[pen_sel]);
                  rsp_data_in.last      = (pixel_ff == LAST_PIXEL);
                  pixel_in              = pixel_ff + 1'b1;
                  pop                   = (pixel_ff == LAST_PIXEL);
               end
            end
            default: ;
         endcase
      end
   end

   // output register and pixel counter
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pixel_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pixel_ff     <= pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // pen palette, power-on values at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PEN_COUNT; i++) begin
            palette_ff[i] <= power_on_colour(PEN_W'(i));
         end
      end else if (pen_we) begin
         palette_ff[head.cmd.pen] <= head.cmd.data[COLOUR_W-1:0];
      end
   end

endmodule

FILE: src/pvs_checker.sv
`include "palette_video_serializer_macros.svh"

module pvs_checker
   import pvs_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   logic [PIX_IDX_W-1:0] beat_ff, beat_in;
   logic                 rsp_take;
   logic                 rsp_hold;
   logic                 last_ok;

   assign rsp_take = rsp_valid && !rsp_stall;
   assign rsp_hold = rsp_valid && rsp_stall;
   assign beat_in  = rsp_take ? beat_ff + 1'b1 : beat_ff;
   assign last_ok  = (rsp_data.last == (beat_ff == LAST_PIXEL));

   // position of the next pixel within its run of eight
   always_ff @(posedge clock) begin
      if (reset) beat_ff <= '0;
      else       beat_ff <= beat_in;
   end

   `PVS_ASSERT_NEXT(a_rsp_valid_held, clock, reset, rsp_hold, rsp_valid, "rsp_valid dropped")
   `PVS_ASSERT_NEXT(a_rsp_data_held, clock, reset, rsp_hold, $stable(rsp_data), "rsp_data changed")
   `PVS_ASSERT_NOW(a_last_on_eighth, clock, reset, rsp_valid, last_ok, "last misplaced")
   `PVS_ASSERT_NOW(a_no_rsp_at_start, clock, reset, $past(reset), !rsp_valid, "rsp at start")
   `PVS_ASSERT_NOW(a_no_stall_at_start, clock, reset, $past(reset), !req_stall, "stall at start")

endmodule

bind palette_video_serializer pvs_checker u_checker (.*);

FILE: tb/sv/palette_video_serializer_test.sv
module palette_video_serializer_test;
   import pvs_pkg::*;

   // codes the block ignores
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] BUS_BANKING = 2'd3;
   localparam int         ROM_ENTRIES = 27;
   localparam int         RUN_PIXELS  = 8;
   localparam int         MAX_WAIT    = 17;
   localparam int         ITEM_TARGET = 370;

   // palette state, expected pixel runs and their checking
   class palette_predictor;
      logic [PEN_W-1:0]    pen_sel;
      logic [COLOUR_W-1:0] palette [PEN_COUNT_DEF];
      logic [1:0]          mode;
      logic [RGB_W-1:0]    hw_rgb [ROM_ENTRIES];
      rsp_payload_type     pixels_due [$];
      int                  failures;

      function new();
         hw_rgb = '{24'h808080, 24'h808080, 24'h00FF80, 24'hFFFF80, 24'h000080,
                    24'hFF0080, 24'h008080, 24'hFF8080, 24'hFF0080, 24'hFFFF80,
                    24'hFFFF00, 24'hFFFFFF, 24'hFF0000, 24'hFF00FF, 24'hFF8000,
                    24'hFF80FF, 24'h000080, 24'h00FF80, 24'h00FF00, 24'h00FFFF,
                    24'h000000, 24'h0000FF, 24'h008000, 24'h0080FF, 24'h800080,
                    24'h8000FF, 24'h800000};
         palette = '{5'd20, 5'd24, 5'd20, 5'd12, 5'd20, 5'd26, 5'd20, 5'd18,
                     5'd20, 5'd6, 5'd20, 5'd14, 5'd20, 5'd10, 5'd20, 5'd22,
                     5'd20};
         pen_sel  = '0;
         mode     = MODE_RESET;
         failures = 0;
      endfunction

      // pen shown at pixel x of a video byte in the current mode
      function logic [PEN_W-1:0] pen_at(logic [7:0] b, int unsigned x);
         int unsigned p;
         p = x / 2;
         case (mode)
            MODE_16_COLOUR: begin
               if (x < 4) return {1'b0, b[1], b[3], b[5], b[7]};
               return {1'b0, b[0], b[2], b[4], b[6]};
            end
            MODE_4_COLOUR: return {3'b000, b[3 - p], b[7 - p]};
            MODE_2_COLOUR: return {4'b0000, b[7 - x]};
            default:       return BORDER_PEN;
         endcase
      endfunction

      // colour of a pen, black past the end of the rom
      function logic [RGB_W-1:0] pen_rgb(logic [PEN_W-1:0] pen);
         logic [COLOUR_W-1:0] hw;
         hw = palette[pen];
         if (hw >= ROM_ENTRIES) return 24'h000000;
         return hw_rgb[hw];
      endfunction

      // update state or queue eight pixels for an accepted transaction
      function void take_item(req_payload_type item);
         rsp_payload_type px;
         case (item.kind)
            KIND_BUS_WRITE: begin
               case (item.value[7:6])
                  BUS_SELECT_PEN:
                     pen_sel = item.value[4] ? BORDER_PEN : {1'b0, item.value[3:0]};
                  BUS_SET_COLOUR: palette[pen_sel] = item.value[4:0];
                  BUS_SET_MODE:   mode = item.value[1:0];
                  default: ;
               endcase
            end
            KIND_VIDEO, KIND_BORDER: begin
               for (int unsigned x = 0; x < RUN_PIXELS; x++) begin
                  px.pixel_rgb = pen_rgb((item.kind == KIND_BORDER) ?
                                         BORDER_PEN : pen_at(item.value, x));
                  px.last      = (x == RUN_PIXELS - 1);
                  pixels_due.push_back(px);
               end
            end
            default: ;
         endcase
      endfunction

      // compare an accepted pixel with the oldest expected one
      function void check_pixel(rsp_payload_type got);
         rsp_payload_type due;
         if (pixels_due.size() == 0) begin
            $error("unexpected pixel: pixel_rgb %06h last %0b", got.pixel_rgb, got.last);
            failures++;
            return;
         end
         due = pixels_due.pop_front();
         if (got.pixel_rgb !== due.pixel_rgb) begin
            $error("pixel_rgb: expected %06h, got %06h", due.pixel_rgb, got.pixel_rgb);
            failures++;
         end
         if (got.last !== due.last) begin
            $error("last: expected %0b, got %0b", due.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;

   palette_predictor board = new();
   int               req_count = 0;
   bit               req_calm  = 1'b0;
   int               rsp_count = 0;
   bit               rsp_calm  = 1'b0;

   palette_video_serializer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // overall time limit
   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

   // present one transaction after a random pause and wait for its acceptance
   task automatic send_item(input logic [1:0] kind, input logic [7:0] value);
      int              gap;
      req_payload_type item;
      if (req_count % 32 == 0) req_calm = ($urandom_range(0, 3) == 0);
      gap        = req_calm ? 0 : $urandom_range(0, MAX_WAIT);
      item.kind  = kind;
      item.value = value;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_item(item);
      req_count++;
   endtask

   // result side: accept, check, then hold off for a random number of cycles
   initial begin
      int hold;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid === 1'b1 && !rsp_stall) begin
               board.check_pixel(rsp_data);
               if (rsp_count % 40 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
               rsp_count++;
               hold = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (hold > 0) begin
               hold--;
            end
            rsp_stall <= (hold != 0);
         end
      end
   end

   // stimulus
   initial begin
      int         pick;
      int         useful;
      logic [5:0] low6;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: power-on palette, every mode, border pen, colours past the rom
      send_item(KIND_VIDEO, 8'h00);
      send_item(KIND_VIDEO, 8'hFF);
      send_item(KIND_BORDER, 8'h00);
      send_item(KIND_UNUSED, 8'hFF);
      send_item(KIND_BUS_WRITE, {BUS_BANKING, 6'h07});
      send_item(KIND_BUS_WRITE, {BUS_SELECT_PEN, 6'h1F});
      send_item(KIND_BUS_WRITE, {BUS_SET_COLOUR, 6'h1B});
      send_item(KIND_BORDER, 8'hFF);
      send_item(KIND_BUS_WRITE, {BUS_SELECT_PEN, 6'h00});
      send_item(KIND_BUS_WRITE, {BUS_SET_COLOUR, 6'h3F});
      send_item(KIND_BUS_WRITE, {BUS_SELECT_PEN, 6'h0F});
      send_item(KIND_BUS_WRITE, {BUS_SET_COLOUR, 6'h00});
      send_item(KIND_BUS_WRITE, {BUS_SET_MODE, 6'h3C});
      send_item(KIND_VIDEO, 8'hAA);
      send_item(KIND_VIDEO, 8'h55);
      send_item(KIND_BUS_WRITE, {BUS_SET_MODE, 6'h02});
      send_item(KIND_VIDEO, 8'hA5);
      send_item(KIND_VIDEO, 8'h00);
      send_item(KIND_BUS_WRITE, {BUS_SET_MODE, 6'h3F});
      send_item(KIND_VIDEO, 8'h5A);
      send_item(KIND_BUS_WRITE, {BUS_SET_MODE, 6'h01});
      send_item(KIND_VIDEO, 8'h3C);
      send_item(KIND_BUS_WRITE, {BUS_SELECT_PEN, 6'h2F});
      send_item(KIND_BUS_WRITE, {BUS_SET_COLOUR, 6'h0A});
      send_item(KIND_VIDEO, 8'hFF);

      // random: palette and mode programming mixed with video bytes, border slots and ignored noise
      useful = 0;
      while (useful < ITEM_TARGET) begin
         pick = $urandom_range(0, 19);
         low6 = 6'($urandom);
         if (pick < 3) begin
            send_item(KIND_BUS_WRITE, {BUS_SELECT_PEN, low6});
            low6 = 6'($urandom);
            send_item(KIND_BUS_WRITE, {BUS_SET_COLOUR, low6});
            useful += 2;
         end else if (pick == 3) begin
            send_item(KIND_BUS_WRITE, {BUS_SET_MODE, low6});
            useful++;
         end else if (pick == 4) begin
            // noise the block ignores
            if ($urandom_range(0, 1) == 0) send_item(KIND_UNUSED, 8'($urandom));
            else send_item(KIND_BUS_WRITE, {BUS_BANKING, low6});
         end else if (pick < 7) begin
            send_item(KIND_BORDER, 8'($urandom));
            useful++;
         end else begin
            send_item(KIND_VIDEO, 8'($urandom));
            useful++;
         end
      end
      req_valid <= 1'b0;

      // drain outstanding pixels, then allow for anything spurious
      while (board.pixels_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.failures == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
